/* hw/rtl/ssi_pkg.sv */
// Shared types, constants and command codes of the stencil smoothness indicator.
package ssi_pkg;

	// Default sizes of the sample words and of the ratio fraction.
	localparam int SAMPLE_BITS_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// Configuration register widths and reset values.
	localparam int EPS_W     = 8;
	localparam int ETA_W     = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 1;

	localparam logic [EPS_W-1:0] EPS_RESET = 8'd1;
	localparam logic [ETA_W-1:0] ETA_RESET = 17'd65536;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ETA     = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SUM,
		OP_RAW,
		OP_MAG,
		OP_DEN,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SQUARE,
		OP_ACCUM,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_OUT
	} ssi_op_t;

	// Command from controller to datapath.
	typedef struct packed {
		ssi_op_t op;
		logic    even;   // divider init: 1 stores the odd ratio and loads the even one
	} ssi_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic last;      // current word closes the point
	} ssi_stat_t;

endpackage

/* hw/rtl/ssi_ctrl.sv */
// Controller state machine: sequences differences, two divisions, square, sum and root.
module ssi_ctrl import ssi_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ssi_stat_t stat,
	output ssi_cmd_t  cmd
);

	localparam int CNT_W = $clog2(FRACTION_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_RAW,
		ST_MAG,
		ST_DEN,
		ST_DIV_INIT,
		ST_DIV,
		ST_SQUARE,
		ST_ACCUM,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              even_q;
	logic              in_ready_q;
	logic              out_valid_q;
	logic              accept;
	logic              deliver;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready_q;
	assign deliver   = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Operation decode from the current state.
	always_comb begin
		cmd.even = even_q;
		case (state_q)
			ST_IDLE:      cmd.op = accept ? OP_LOAD : OP_NOP;
			ST_SUM:       cmd.op = OP_SUM;
			ST_RAW:       cmd.op = OP_RAW;
			ST_MAG:       cmd.op = OP_MAG;
			ST_DEN:       cmd.op = OP_DEN;
			ST_DIV_INIT:  cmd.op = OP_DIV_INIT;
			ST_DIV:       cmd.op = OP_DIV_STEP;
			ST_SQUARE:    cmd.op = OP_SQUARE;
			ST_ACCUM:     cmd.op = OP_ACCUM;
			ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
			ST_SQRT:      cmd.op = OP_SQRT_STEP;
			ST_OUT:       cmd.op = deliver ? OP_OUT : OP_NOP;
			default:      cmd.op = OP_NOP;
		endcase
	end

	// State, step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			even_q      <= 1'b0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// A taken word clears the flag unless a new one is delivered in its place.
			if (out_valid_q && out_ready && !deliver) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_RAW;
				ST_RAW: state_q <= ST_MAG;
				ST_MAG: state_q <= ST_DEN;
				ST_DEN: begin
					even_q  <= 1'b0;
					state_q <= ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					cnt_q   <= CNT_W'(FRACTION_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (even_q) begin
							state_q <= ST_SQUARE;
						end else begin
							even_q  <= 1'b1;
							state_q <= ST_DIV_INIT;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQUARE: state_q <= ST_ACCUM;
				ST_ACCUM: begin
					if (stat.last) begin
						state_q <= ST_SQRT_INIT;
					end else begin
						in_ready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_SQRT_INIT: begin
					cnt_q   <= CNT_W'(FRACTION_BITS);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (deliver) begin
						out_valid_q <= 1'b1;
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/ssi_dp.sv */
// Datapath: stencil differences, shared restoring divider, square, sum and digit square root.
module ssi_dp import ssi_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssi_cmd_t                      cmd,
	output ssi_stat_t                     stat,
	input  logic signed [SAMPLE_BITS-1:0] sample_minus_two,
	input  logic signed [SAMPLE_BITS-1:0] sample_minus_one,
	input  logic signed [SAMPLE_BITS-1:0] sample_center,
	input  logic signed [SAMPLE_BITS-1:0] sample_plus_one,
	input  logic signed [SAMPLE_BITS-1:0] sample_plus_two,
	input  logic signed [SAMPLE_BITS-1:0] reference_value,
	input  logic                          last_direction,
	input  logic [EPS_W-1:0]              epsilon,
	input  logic [ETA_W-1:0]              eta,
	output logic [FRACTION_BITS:0]        indicator,
	output logic                          over_threshold
);

	localparam int S   = SAMPLE_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int RW  = S + 5;          // signed raw differences
	localparam int DW  = S + 6;          // magnitudes and denominators
	localparam int AW  = 2 * F + 2;      // square sum, Q2.2F
	localparam int QW  = 2 * F;          // squared ratio
	localparam int SRW = F + 3;          // root remainder
	localparam int IW  = F + 1;          // root
	localparam int CMW = (IW > ETA_W) ? IW : ETA_W;

	// Captured word.
	logic signed [S-1:0] mm_q, m_q, c_q, p_q, pp_q, rv_q;
	logic                last_q;

	// First sums.
	logic signed [S:0]   a_q, b_q, e_q, f_q, c2_q;
	logic signed [S+2:0] c6_q;
	logic [S-1:0]        rvm_q;

	// Raw differences.
	logic signed [RW-1:0] r1_q, r2_q, r3_q, r4_q;
	logic [DW-1:0]        d0_q;

	// Magnitudes and denominators.
	logic [DW-1:0] d1_q, d2_q, d3_q, d4_q;
	logic [DW-1:0] den_odd_q, den_even_q;

	// Divider.
	logic [DW-1:0] rem_q, dvs_q;
	logic [F-1:0]  quo_q, odd_q;
	logic          dz_q;

	// Square, sum and root.
	logic [QW-1:0]  sq_q;
	logic [AW-1:0]  acc_q;
	logic [AW-1:0]  x_q;
	logic [SRW-1:0] srem_q;
	logic [IW-1:0]  root_q;

	logic [IW-1:0] indicator_q;
	logic          over_q;

	// Next-value logic.
	logic signed [S:0]    c2_n;
	logic signed [S+2:0]  c6_n;
	logic [S-1:0]         rvm_n;
	logic [RW-1:0]        m1, m2, m3, m4;
	logic [DW:0]          div_sh;
	logic                 div_ge;
	logic [F-1:0]         even_res, big;
	logic [AW:0]          acc_sum;
	logic [SRW-1:0]       sq_remx, sq_trial;
	logic                 sq_ge;

	assign stat.last      = last_q;
	assign indicator      = indicator_q;
	assign over_threshold = over_q;

	// Doubled and sextupled center, reference magnitude.
	always_comb begin
		c2_n  = (S+1)'(c_q) <<< 1;
		c6_n  = ((S+3)'(c_q) <<< 2) + ((S+3)'(c_q) <<< 1);
		rvm_n = rv_q[S-1] ? (~rv_q + 1'b1) : rv_q;
	end

	// Magnitudes of the raw differences.
	always_comb begin
		m1 = r1_q[RW-1] ? (~r1_q + 1'b1) : r1_q;
		m2 = r2_q[RW-1] ? (~r2_q + 1'b1) : r2_q;
		m3 = r3_q[RW-1] ? (~r3_q + 1'b1) : r3_q;
		m4 = r4_q[RW-1] ? (~r4_q + 1'b1) : r4_q;
	end

	// One quotient bit per cycle; the remainder stays below the divisor while epsilon is nonzero.
	always_comb begin
		div_sh   = {rem_q, 1'b0};
		div_ge   = div_sh >= {1'b0, dvs_q};
		even_res = dz_q ? '0 : quo_q;
		big      = (odd_q > even_res) ? odd_q : even_res;
		acc_sum  = {1'b0, acc_q} + (AW+1)'(sq_q);
	end

	// One root bit per cycle, two radicand bits consumed.
	always_comb begin
		sq_remx  = {srem_q[SRW-3:0], x_q[AW-1:AW-2]};
		sq_trial = {root_q, 2'b01};
		sq_ge    = sq_remx >= sq_trial;
	end

	// Square sum, cleared at reset and when a point closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (cmd.op)
				OP_ACCUM:     acc_q <= acc_sum[AW] ? '1 : acc_sum[AW-1:0];
				OP_SQRT_INIT: acc_q <= '0;
				default:      acc_q <= acc_q;
			endcase
		end
	end

	// Payload registers, stepped by the controller.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mm_q   <= sample_minus_two;
				m_q    <= sample_minus_one;
				c_q    <= sample_center;
				p_q    <= sample_plus_one;
				pp_q   <= sample_plus_two;
				rv_q   <= reference_value;
				last_q <= last_direction;
			end
			OP_SUM: begin
				a_q   <= (S+1)'(p_q) - (S+1)'(m_q);
				b_q   <= (S+1)'(p_q) + (S+1)'(m_q);
				e_q   <= (S+1)'(pp_q) - (S+1)'(mm_q);
				f_q   <= (S+1)'(pp_q) + (S+1)'(mm_q);
				c2_q  <= c2_n;
				c6_q  <= c6_n;
				rvm_q <= rvm_n;
			end
			OP_RAW: begin
				r1_q <= RW'(a_q);
				r2_q <= RW'(b_q) - RW'(c2_q);
				r3_q <= RW'(e_q) - (RW'(a_q) <<< 1);
				r4_q <= RW'(f_q) - (RW'(b_q) <<< 2) + RW'(c6_q);
				d0_q <= DW'(rvm_q) << 1;
			end
			OP_MAG: begin
				d1_q <= DW'(m1);
				d2_q <= DW'(m2) << 1;
				d3_q <= DW'(m3);
				d4_q <= DW'(m4) << 1;
			end
			OP_DEN: begin
				den_odd_q  <= d0_q + d1_q + d3_q + DW'(epsilon);
				den_even_q <= d0_q + d2_q + d4_q + DW'(epsilon);
			end
			OP_DIV_INIT: begin
				quo_q <= '0;
				if (cmd.even) begin
					odd_q <= dz_q ? '0 : quo_q;
					rem_q <= d4_q;
					dvs_q <= den_even_q;
					dz_q  <= den_even_q == '0;
				end else begin
					rem_q <= d3_q;
					dvs_q <= den_odd_q;
					dz_q  <= den_odd_q == '0;
				end
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? DW'(div_sh - {1'b0, dvs_q}) : DW'(div_sh);
				quo_q <= {quo_q[F-2:0], div_ge};
			end
			OP_SQUARE: begin
				sq_q <= QW'(big) * QW'(big);
			end
			OP_SQRT_INIT: begin
				x_q    <= acc_q;
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				x_q    <= x_q << 2;
				srem_q <= sq_ge ? (sq_remx - sq_trial) : sq_remx;
				root_q <= {root_q[IW-2:0], sq_ge};
			end
			OP_OUT: begin
				indicator_q <= root_q;
				over_q      <= CMW'(root_q) > CMW'(eta);
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

endmodule

/* hw/rtl/stencil_smoothness_indicator.sv */
// Top level of the stencil smoothness indicator: ports, configuration registers, checks.
// Each input word carries one direction's five-point stencil and a reference value.
// The block forms the odd and even difference ratios as unsigned fractions, squares
// the larger one and adds it to a saturating sum; a word flagged last_direction then
// yields one output word with the floor square root of that sum (Q1.FRACTION_BITS)
// and a flag set when it exceeds eta_threshold, and the sum starts over. One word is
// processed at a time: in_ready rises again when the word is done, and a closing word
// first runs the square root and hands its result to the output register. The work
// is done by the shared restoring divider, which produces one quotient bit per cycle
// for each of the two ratios, and by the square root unit, which produces one root
// bit per cycle. A finished output word waits in its own register, so the next input
// word is taken and worked on while it is pending. Configuration is written through
// cfg_we, cfg_index and cfg_data: index 0 is epsilon_lsb, index 1 is eta_threshold.
module stencil_smoothness_indicator import ssi_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_minus_two,
	input  logic signed [SAMPLE_BITS-1:0] sample_minus_one,
	input  logic signed [SAMPLE_BITS-1:0] sample_center,
	input  logic signed [SAMPLE_BITS-1:0] sample_plus_one,
	input  logic signed [SAMPLE_BITS-1:0] sample_plus_two,
	input  logic signed [SAMPLE_BITS-1:0] reference_value,
	input  logic                          last_direction,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [FRACTION_BITS:0]        indicator,
	output logic                          over_threshold
);

	logic [EPS_W-1:0] epsilon_q;
	logic [ETA_W-1:0] eta_q;
	ssi_cmd_t         cmd;
	ssi_stat_t        stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= EPS_RESET;
			eta_q     <= ETA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EPSILON: epsilon_q <= cfg_data[EPS_W-1:0];
				REG_ETA:     eta_q     <= cfg_data[ETA_W-1:0];
				default:     eta_q     <= eta_q;
			endcase
		end
	end

	// Controller.
	ssi_ctrl #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath.
	ssi_dp #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.sample_minus_two(sample_minus_two),
		.sample_minus_one(sample_minus_one),
		.sample_center   (sample_center),
		.sample_plus_one (sample_plus_one),
		.sample_plus_two (sample_plus_two),
		.reference_value (reference_value),
		.last_direction  (last_direction),
		.epsilon         (epsilon_q),
		.eta             (eta_q),
		.indicator       (indicator),
		.over_threshold  (over_threshold)
	);

	// One word at a time: an accepted word closes the input until it is done.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is still in work");

	// A new result only appears at the end of work, never out of an idle cycle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in work");

	// A result is not raised right after a non-closing word is accepted.
	a_result_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_direction |=> !$rose(out_valid))
		else $error("result raised right after a non-closing word");

endmodule
